>>> rtl/afdr_pkg.sv
// afdr_pkg: shared types and constants for the ascii frame duty regulator
// no dependencies; used by the interfaces, register block, controller, datapath and top
package afdr_pkg;

  // frame layout
  localparam int FRAME_DIGITS = 5;
  localparam int FRAME_LEN    = 3 * FRAME_DIGITS;
  localparam int POS_W        = $clog2(FRAME_LEN + 1);

  // field widths
  localparam int BYTE_W   = 8;
  localparam int MEAS_W   = 17;
  localparam int FRAC_BITS = 16;
  localparam int DUTY_W   = FRAC_BITS + 1;
  localparam int ERR_W    = DUTY_W + 1;
  localparam int GAIN_W   = 18;
  localparam int PERIOD_W = 16;
  localparam int PW_W     = 16;

  // shared multiplier and accumulator widths
  localparam int MUL_W  = 20;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 2;

  // divider: quotient bits kept below the overflow check
  localparam int DIV_STEPS = DUTY_W + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [DUTY_W-1:0] FULL_SCALE = DUTY_W'(1) << FRAC_BITS;

  // apb register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_KP     = 2'd0;
  localparam logic [1:0] REG_KI     = 2'd1;
  localparam logic [1:0] REG_KD     = 2'd2;
  localparam logic [1:0] REG_PERIOD = 2'd3;

  localparam logic [GAIN_W-1:0]   KP_RESET     = GAIN_W'(35081);
  localparam logic [GAIN_W-1:0]   KI_RESET     = GAIN_W'(8742);
  localparam logic [GAIN_W-1:0]   KD_RESET     = '0;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // register file contents seen by the datapath
  typedef struct packed {
    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   ki;
    logic [GAIN_W-1:0]   kd;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

  // operand select for the shared multiplier
  typedef enum logic [2:0] {
    MUL_SD = 3'd0,
    MUL_KP = 3'd1,
    MUL_KI = 3'd2,
    MUL_KD = 3'd3,
    MUL_PW = 3'd4
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     byte_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_init;
    logic     div_step;
    logic     acc_load;
    logic     acc_add;
    logic     duty_update;
    logic     out_load;
  } ctl_t;

endpackage

>>> rtl/afdr_in_if.sv
// afdr_in_if: input word channel (valid/ready plus cmd and rx_byte)
// depends on afdr_pkg for widths
interface afdr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [afdr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

>>> rtl/afdr_out_if.sv
// afdr_out_if: result word channel (valid/ready plus status and measurements)
// depends on afdr_pkg for widths
interface afdr_out_if;
  logic                          valid;
  logic                          ready;
  logic [afdr_pkg::BYTE_W-1:0]   echo_byte;
  logic                          frame_done;
  logic                          frame_bad;
  logic [afdr_pkg::MEAS_W-1:0]   measured_voltage;
  logic [afdr_pkg::MEAS_W-1:0]   measured_current;
  logic [afdr_pkg::MEAS_W-1:0]   target_voltage;
  logic [afdr_pkg::DUTY_W-1:0]   duty_value;
  logic [afdr_pkg::PW_W-1:0]     pulse_width;

  modport source (output valid, output echo_byte, output frame_done, output frame_bad,
                  output measured_voltage, output measured_current,
                  output target_voltage, output duty_value, output pulse_width,
                  input ready);
  modport sink   (input valid, input echo_byte, input frame_done, input frame_bad,
                  input measured_voltage, input measured_current,
                  input target_voltage, input duty_value, input pulse_width,
                  output ready);
endinterface

>>> rtl/ascii_frame_duty_regulator_top.sv
// ascii frame duty regulator top: a byte word steps the frame parser; a tick word forms
// the target-duty product and runs the 18-step restoring divider plus 5 pid steps
// on one shared 20x20 multiplier; both then form the pulse width product
// one word in flight; the next word is taken while the previous result waits
// rst_n is synchronous active low: clears frame state, duty, error history, result valid,
// and loads the gain and period registers with their defaults
module ascii_frame_duty_regulator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  afdr_in_if.sink                       in_ch,
  afdr_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [afdr_pkg::ADDR_W-1:0]   paddr,
  input  logic [afdr_pkg::DATA_W-1:0]   pwdata,
  output logic [afdr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  afdr_pkg::cfg_t cfg;
  afdr_pkg::ctl_t ctl;
  logic           in_ready;
  logic           out_valid;

  // configuration registers
  afdr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  afdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  // datapath
  afdr_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .cfg              (cfg),
    .rx_byte          (in_ch.rx_byte),
    .echo_byte        (out_ch.echo_byte),
    .frame_done       (out_ch.frame_done),
    .frame_bad        (out_ch.frame_bad),
    .measured_voltage (out_ch.measured_voltage),
    .measured_current (out_ch.measured_current),
    .target_voltage   (out_ch.target_voltage),
    .duty_value       (out_ch.duty_value),
    .pulse_width      (out_ch.pulse_width)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

>>> rtl/afdr_regs.sv
// afdr_regs: apb register block holding the pid gains and the pwm period
// depends on afdr_pkg for the register map and cfg_t
module afdr_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [afdr_pkg::ADDR_W-1:0]   paddr,
  input  logic [afdr_pkg::DATA_W-1:0]   pwdata,
  output logic [afdr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output afdr_pkg::cfg_t                cfg
);

  afdr_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp     <= afdr_pkg::KP_RESET;
      cfg_r.ki     <= afdr_pkg::KI_RESET;
      cfg_r.kd     <= afdr_pkg::KD_RESET;
      cfg_r.period <= afdr_pkg::PERIOD_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        afdr_pkg::REG_KP:     cfg_r.kp     <= pwdata[afdr_pkg::GAIN_W-1:0];
        afdr_pkg::REG_KI:     cfg_r.ki     <= pwdata[afdr_pkg::GAIN_W-1:0];
        afdr_pkg::REG_KD:     cfg_r.kd     <= pwdata[afdr_pkg::GAIN_W-1:0];
        afdr_pkg::REG_PERIOD: cfg_r.period <= pwdata[afdr_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      afdr_pkg::REG_KP:     prdata = afdr_pkg::DATA_W'(cfg_r.kp);
      afdr_pkg::REG_KI:     prdata = afdr_pkg::DATA_W'(cfg_r.ki);
      afdr_pkg::REG_KD:     prdata = afdr_pkg::DATA_W'(cfg_r.kd);
      afdr_pkg::REG_PERIOD: prdata = afdr_pkg::DATA_W'(cfg_r.period);
      default:              prdata = '0;
    endcase
  end

endmodule

>>> rtl/afdr_ctrl.sv
// afdr_ctrl: sequencer for byte and tick words, drives the datapath commands
// depends on afdr_pkg for ctl_t and the divider step count
module afdr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_cmd,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output afdr_pkg::ctl_t ctl
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_BYTE  = 12'b0000_0000_0010,
    ST_PROD  = 12'b0000_0000_0100,
    ST_DINIT = 12'b0000_0000_1000,
    ST_DIV   = 12'b0000_0001_0000,
    ST_KP    = 12'b0000_0010_0000,
    ST_KI    = 12'b0000_0100_0000,
    ST_KD    = 12'b0000_1000_0000,
    ST_ACC   = 12'b0001_0000_0000,
    ST_UPD   = 12'b0010_0000_0000,
    ST_PW    = 12'b0100_0000_0000,
    ST_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [afdr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    ctl.mul_sel = afdr_pkg::MUL_SD;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = (in_cmd == afdr_pkg::CMD_TICK) ? ST_PROD : ST_BYTE;
        end
      end
      ST_BYTE: begin
        ctl.byte_step = 1'b1;
        state_nxt     = ST_PW;
      end
      ST_PROD: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = afdr_pkg::MUL_SD;
        state_nxt   = ST_DINIT;
      end
      ST_DINIT: begin
        ctl.div_init = 1'b1;
        cnt_nxt      = afdr_pkg::CNT_W'(afdr_pkg::DIV_STEPS - 1);
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_KP;
      end
      ST_KP: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = afdr_pkg::MUL_KP;
        state_nxt   = ST_KI;
      end
      ST_KI: begin
        ctl.mul_en   = 1'b1;
        ctl.mul_sel  = afdr_pkg::MUL_KI;
        ctl.acc_load = 1'b1;
        state_nxt    = ST_KD;
      end
      ST_KD: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = afdr_pkg::MUL_KD;
        ctl.acc_add = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc_add = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        ctl.duty_update = 1'b1;
        state_nxt       = ST_PW;
      end
      ST_PW: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = afdr_pkg::MUL_PW;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    if (ctl.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // one word in flight at a time
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // divider runs its fixed step count then goes to the pid steps
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == '0) |=> (state_r == ST_KP))
    else $error("divider did not hand over to the pid steps");

  // a result load always shows up as a valid word
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> out_valid_r)
    else $error("result load without valid");

endmodule

>>> rtl/afdr_dpath.sv
// afdr_dpath: frame parser, restoring divider, shared multiplier, pid update, result register
// depends on afdr_pkg for widths, cfg_t and ctl_t
module afdr_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  afdr_pkg::ctl_t                 ctl,
  input  afdr_pkg::cfg_t                 cfg,
  input  logic [afdr_pkg::BYTE_W-1:0]    rx_byte,
  output logic [afdr_pkg::BYTE_W-1:0]    echo_byte,
  output logic                           frame_done,
  output logic                           frame_bad,
  output logic [afdr_pkg::MEAS_W-1:0]    measured_voltage,
  output logic [afdr_pkg::MEAS_W-1:0]    measured_current,
  output logic [afdr_pkg::MEAS_W-1:0]    target_voltage,
  output logic [afdr_pkg::DUTY_W-1:0]    duty_value,
  output logic [afdr_pkg::PW_W-1:0]      pulse_width
);

  localparam int MEAS_W = afdr_pkg::MEAS_W;
  localparam int DUTY_W = afdr_pkg::DUTY_W;
  localparam int ERR_W  = afdr_pkg::ERR_W;
  localparam int MUL_W  = afdr_pkg::MUL_W;
  localparam int PROD_W = afdr_pkg::PROD_W;
  localparam int ACC_W  = afdr_pkg::ACC_W;
  localparam int FRAC   = afdr_pkg::FRAC_BITS;
  localparam int QW     = afdr_pkg::DIV_STEPS;
  localparam int POS_W  = afdr_pkg::POS_W;
  localparam logic signed [ACC_W-1:0] FULL_ACC   = ACC_W'(afdr_pkg::FULL_SCALE);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC - 1);

  // frame state
  logic [POS_W-1:0]         pos_r;
  logic [MEAS_W-1:0]        volt_acc_r, curr_acc_r, set_acc_r;
  logic                     bad_char_r;
  logic [MEAS_W-1:0]        volt_r, curr_r, set_r;
  logic [afdr_pkg::BYTE_W-1:0] byte_r;
  logic [afdr_pkg::BYTE_W-1:0] echo_r;
  logic                     done_r, bad_r;

  // control loop state
  logic [DUTY_W-1:0]        duty_r;
  logic signed [ERR_W-1:0]  ep_r, ep2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  // divider state
  logic [MEAS_W-1:0]        rem_r;
  logic [QW-1:0]            num_r, quo_r;
  logic                     sat_r;

  // result register
  logic [afdr_pkg::BYTE_W-1:0] o_echo_r;
  logic                        o_done_r, o_bad_r;
  logic [MEAS_W-1:0]           o_volt_r, o_curr_r, o_set_r;
  logic [DUTY_W-1:0]           o_duty_r;
  logic [afdr_pkg::PW_W-1:0]   o_pw_r;

  // byte decode
  logic                     is_digit;
  logic [3:0]               digit;
  logic [MEAS_W-1:0]        volt_mac, curr_mac, set_mac;
  logic                     last_char;
  logic                     frame_ok;

  always_comb begin
    is_digit  = (byte_r >= "0") && (byte_r <= "9");
    digit     = is_digit ? 4'(byte_r - "0") : 4'd0;
    volt_mac  = volt_acc_r;
    curr_mac  = curr_acc_r;
    set_mac   = set_acc_r;
    if (pos_r < POS_W'(afdr_pkg::FRAME_DIGITS)) begin
      volt_mac = MEAS_W'((volt_acc_r << 3) + (volt_acc_r << 1) + MEAS_W'(digit));
    end else if (pos_r < POS_W'(2 * afdr_pkg::FRAME_DIGITS)) begin
      curr_mac = MEAS_W'((curr_acc_r << 3) + (curr_acc_r << 1) + MEAS_W'(digit));
    end else begin
      set_mac  = MEAS_W'((set_acc_r << 3) + (set_acc_r << 1) + MEAS_W'(digit));
    end
    last_char = (pos_r == POS_W'(afdr_pkg::FRAME_LEN - 1));
    frame_ok  = !bad_char_r && is_digit;
  end

  // expected duty and error terms
  logic [DUTY_W-1:0]        expected;
  logic signed [ERR_W:0]    e_wide;
  logic signed [ERR_W-1:0]  e;
  logic signed [ERR_W:0]    d1;
  logic signed [MUL_W-1:0]  d2;

  always_comb begin
    if (sat_r || (quo_r > QW'(afdr_pkg::FULL_SCALE))) expected = afdr_pkg::FULL_SCALE;
    else expected = quo_r[DUTY_W-1:0];
    e_wide = $signed({2'b00, expected}) - $signed({2'b00, duty_r});
    e      = e_wide[ERR_W-1:0];
    d1     = $signed({e[ERR_W-1], e}) - $signed({ep_r[ERR_W-1], ep_r});
    d2     = $signed({{2{e[ERR_W-1]}}, e})
           - $signed({ep_r[ERR_W-1], ep_r, 1'b0})
           + $signed({{2{ep2_r[ERR_W-1]}}, ep2_r});
  end

  // shared multiplier operand select
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    unique case (ctl.mul_sel)
      afdr_pkg::MUL_SD: begin
        mul_a = $signed(MUL_W'(set_r));
        mul_b = $signed(MUL_W'(duty_r));
      end
      afdr_pkg::MUL_KP: begin
        mul_a = $signed(MUL_W'(cfg.kp));
        mul_b = $signed({d1[ERR_W], d1});
      end
      afdr_pkg::MUL_KI: begin
        mul_a = $signed(MUL_W'(cfg.ki));
        mul_b = $signed({{2{e[ERR_W-1]}}, e});
      end
      afdr_pkg::MUL_KD: begin
        mul_a = $signed(MUL_W'(cfg.kd));
        mul_b = d2;
      end
      afdr_pkg::MUL_PW: begin
        mul_a = $signed(MUL_W'(cfg.period));
        mul_b = $signed(MUL_W'(duty_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // divider step: one quotient bit per cycle
  logic [MEAS_W+1:0]        trial;
  logic                     q_bit;
  logic [MEAS_W:0]          shifted;

  always_comb begin
    shifted = {rem_r, num_r[QW-1]};
    trial   = {1'b0, shifted} - {2'b00, volt_r};
    q_bit   = !trial[MEAS_W+1];
  end

  // pid rounding and clamp
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  nd;
  logic [DUTY_W-1:0]        duty_nxt;

  always_comb begin
    rnd = (acc_r + ROUND_HALF) >>> FRAC;
    nd  = $signed(ACC_W'(duty_r)) + rnd;
    if (nd < 0) duty_nxt = '0;
    else if (nd > FULL_ACC) duty_nxt = afdr_pkg::FULL_SCALE;
    else duty_nxt = nd[DUTY_W-1:0];
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      volt_acc_r <= '0;
      curr_acc_r <= '0;
      set_acc_r  <= '0;
      bad_char_r <= 1'b0;
      volt_r     <= '0;
      curr_r     <= '0;
      set_r      <= '0;
      duty_r     <= '0;
      ep_r       <= '0;
      ep2_r      <= '0;
    end else begin
      if (ctl.byte_step) begin
        if (last_char) begin
          pos_r      <= '0;
          volt_acc_r <= '0;
          curr_acc_r <= '0;
          set_acc_r  <= '0;
          bad_char_r <= 1'b0;
          if (frame_ok) begin
            volt_r <= volt_mac;
            curr_r <= curr_mac;
            set_r  <= set_mac;
          end
        end else begin
          pos_r      <= pos_r + 1'b1;
          volt_acc_r <= volt_mac;
          curr_acc_r <= curr_mac;
          set_acc_r  <= set_mac;
          bad_char_r <= bad_char_r || !is_digit;
        end
      end
      if (ctl.duty_update) begin
        duty_r <= duty_nxt;
        ep2_r  <= ep_r;
        ep_r   <= e;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      byte_r <= rx_byte;
      echo_r <= '0;
      done_r <= 1'b0;
      bad_r  <= 1'b0;
    end
    if (ctl.byte_step) begin
      echo_r <= byte_r;
      done_r <= last_char;
      bad_r  <= last_char && !frame_ok;
    end
    if (ctl.mul_en) prod_r <= mul_p;
    if (ctl.acc_load) acc_r <= ACC_W'(prod_r);
    else if (ctl.acc_add) acc_r <= acc_r + ACC_W'(prod_r);
    // overflow and zero-voltage checks ahead of the quotient bits
    if (ctl.div_init) begin
      sat_r <= (volt_r == '0) ||
               ({1'b0, prod_r[2*DUTY_W-1:QW]} >= volt_r);
      rem_r <= MEAS_W'(prod_r[2*DUTY_W-1:QW]);
      num_r <= prod_r[QW-1:0];
      quo_r <= '0;
    end else if (ctl.div_step) begin
      rem_r <= q_bit ? trial[MEAS_W-1:0] : shifted[MEAS_W-1:0];
      num_r <= {num_r[QW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], q_bit};
    end
    if (ctl.out_load) begin
      o_echo_r <= echo_r;
      o_done_r <= done_r;
      o_bad_r  <= bad_r;
      o_volt_r <= volt_r;
      o_curr_r <= curr_r;
      o_set_r  <= set_r;
      o_duty_r <= duty_r;
      o_pw_r   <= prod_r[FRAC+afdr_pkg::PW_W-1:FRAC];
    end
  end

  assign echo_byte        = o_echo_r;
  assign frame_done       = o_done_r;
  assign frame_bad        = o_bad_r;
  assign measured_voltage = o_volt_r;
  assign measured_current = o_curr_r;
  assign target_voltage   = o_set_r;
  assign duty_value       = o_duty_r;
  assign pulse_width      = o_pw_r;

  // duty never leaves [0, full scale]
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r <= afdr_pkg::FULL_SCALE)
    else $error("duty above full scale");

  // character position stays inside the frame
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < POS_W'(afdr_pkg::FRAME_LEN))
    else $error("frame position out of range");

  // last character of a frame restarts the parser
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.byte_step && last_char) |=> (pos_r == '0 && !bad_char_r))
    else $error("frame parser did not restart");

endmodule
